// ===== design/kvbt_pkg.sv =====
`default_nettype none

package kvbt_pkg;

    // decoupling queue between the byte parser and the character emitter
    localparam int KVBT_QUEUE_DEPTH = 4;
    localparam int KVBT_QIDX_W      = $clog2(KVBT_QUEUE_DEPTH);
    localparam int KVBT_QCNT_W      = $clog2(KVBT_QUEUE_DEPTH + 1);

    // blob signature
    localparam int KVBT_SIG_LEN = 4;
    localparam int KVBT_HPOS_W  = $clog2(KVBT_SIG_LEN);
    localparam logic [7:0] KVBT_SIG [KVBT_SIG_LEN] = '{8'h00, 8'h45, 8'h4D, 8'hFF};

    // separator characters
    localparam logic [7:0] KVBT_CHAR_EQ = 8'h3D;
    localparam logic [7:0] KVBT_CHAR_NL = 8'h0A;

    typedef enum logic [1:0] {
        KVBT_ST_OK    = 2'd0,
        KVBT_ST_SIG   = 2'd1,
        KVBT_ST_TRUNC = 2'd2
    } t_end_status;

    // one parsed byte: which results it causes, in emission order
    typedef struct packed {
        logic [7:0]  byte_val;
        logic        has_char;
        logic        has_eq;
        logic        has_nl;
        logic        has_end;
        t_end_status status;
    } t_kvbt_cmd;

endpackage

`default_nettype wire

// ===== design/kvbt_if.sv =====
`default_nettype none

// blob byte channel
interface kvbt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] blob_byte;
    logic       blob_last;

    modport source (output valid, output blob_byte, output blob_last, input ready);
    modport sink   (input valid, input blob_byte, input blob_last, output ready);
endinterface

// text character channel
interface kvbt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       char_valid;
    logic       stream_end;
    logic [1:0] end_status;

    modport source (output valid, output text_char, output char_valid,
                    output stream_end, output end_status, input ready);
    modport sink   (input valid, input text_char, input char_valid,
                    input stream_end, input end_status, output ready);
endinterface

`default_nettype wire

// ===== design/kvbt_front.sv =====
`default_nettype none

module kvbt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    kvbt_in_if.sink            i_blob,
    input  wire logic          i_q_ready,
    output logic               o_push,
    output kvbt_pkg::t_kvbt_cmd o_cmd
);
    import kvbt_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_KEYLEN,
        PH_VALLEN,
        PH_KEY,
        PH_VALUE,
        PH_DONE,
        PH_ERROR
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [KVBT_HPOS_W-1:0] r_hpos, n_hpos;
    logic [7:0]             r_key_rem, n_key_rem;
    logic [7:0]             r_val_rem, n_val_rem;
    t_kvbt_cmd              w_cmd;
    logic                   w_accept;

    // take a byte whenever the queue has room
    assign i_blob.ready = i_q_ready;
    assign w_accept     = i_blob.valid && i_q_ready;

    // classify the byte against the parser phase
    always_comb begin
        n_phase      = r_phase;
        n_hpos       = r_hpos;
        n_key_rem    = r_key_rem;
        n_val_rem    = r_val_rem;
        w_cmd        = '0;
        w_cmd.byte_val = i_blob.blob_byte;
        w_cmd.status = KVBT_ST_OK;
        case (r_phase)
            PH_HEADER: begin
                if (i_blob.blob_byte != KVBT_SIG[r_hpos]) begin
                    n_phase      = PH_ERROR;
                    w_cmd.status = KVBT_ST_SIG;
                end else if (r_hpos == KVBT_HPOS_W'(KVBT_SIG_LEN - 1)) begin
                    n_hpos       = '0;
                    n_phase      = PH_KEYLEN;
                    w_cmd.status = KVBT_ST_OK;
                end else begin
                    n_hpos       = r_hpos + KVBT_HPOS_W'(1);
                    w_cmd.status = KVBT_ST_SIG;
                end
            end
            PH_KEYLEN: begin
                if (i_blob.blob_byte == 8'd0) begin
                    n_phase      = PH_DONE;
                    w_cmd.status = KVBT_ST_OK;
                end else begin
                    n_key_rem    = i_blob.blob_byte;
                    n_phase      = PH_VALLEN;
                    w_cmd.status = KVBT_ST_TRUNC;
                end
            end
            PH_VALLEN: begin
                n_val_rem    = i_blob.blob_byte;
                n_phase      = PH_KEY;
                w_cmd.status = KVBT_ST_TRUNC;
            end
            PH_KEY: begin
                w_cmd.has_char = 1'b1;
                n_key_rem      = r_key_rem - 8'd1;
                w_cmd.status   = KVBT_ST_TRUNC;
                if (r_key_rem == 8'd1) begin
                    w_cmd.has_eq = 1'b1;
                    if (r_val_rem == 8'd0) begin
                        w_cmd.has_nl = 1'b1;
                        n_phase      = PH_KEYLEN;
                        w_cmd.status = KVBT_ST_OK;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                w_cmd.has_char = 1'b1;
                n_val_rem      = r_val_rem - 8'd1;
                w_cmd.status   = KVBT_ST_TRUNC;
                if (r_val_rem == 8'd1) begin
                    w_cmd.has_nl = 1'b1;
                    n_phase      = PH_KEYLEN;
                    w_cmd.status = KVBT_ST_OK;
                end
            end
            PH_ERROR: begin
                w_cmd.status = KVBT_ST_SIG;
            end
            default: begin
                w_cmd.status = KVBT_ST_OK;
            end
        endcase

        // last byte closes the blob and rearms the parser
        if (i_blob.blob_last) begin
            w_cmd.has_end = 1'b1;
            n_phase       = PH_HEADER;
            n_hpos        = '0;
            n_key_rem     = 8'd0;
            n_val_rem     = 8'd0;
        end
    end

    // only bytes that cause results go into the queue
    assign o_push = w_accept &&
                    (w_cmd.has_char || w_cmd.has_eq || w_cmd.has_nl || w_cmd.has_end);
    assign o_cmd  = w_cmd;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hpos    <= '0;
            r_key_rem <= 8'd0;
            r_val_rem <= 8'd0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_hpos    <= n_hpos;
            r_key_rem <= n_key_rem;
            r_val_rem <= n_val_rem;
        end
    end

endmodule

`default_nettype wire

// ===== design/kvbt_queue.sv =====
`default_nettype none

module kvbt_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire kvbt_pkg::t_kvbt_cmd  i_push_cmd,
    output logic                      o_not_full,
    output logic                      o_head_valid,
    output kvbt_pkg::t_kvbt_cmd       o_head,
    input  wire logic                 i_pop
);
    import kvbt_pkg::*;

    t_kvbt_cmd              r_mem [KVBT_QUEUE_DEPTH];
    logic [KVBT_QIDX_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [KVBT_QCNT_W-1:0] r_count;
    logic                   w_do_push, w_do_pop;

    assign o_not_full   = (r_count != KVBT_QCNT_W'(KVBT_QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_do_push    = i_push && o_not_full;
    assign w_do_pop     = i_pop && o_head_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == KVBT_QIDX_W'(KVBT_QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + KVBT_QIDX_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == KVBT_QIDX_W'(KVBT_QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + KVBT_QIDX_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + KVBT_QCNT_W'(1);
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - KVBT_QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/kvbt_back.sv =====
`default_nettype none

module kvbt_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_head_valid,
    input  wire kvbt_pkg::t_kvbt_cmd i_head,
    output logic                     o_pop,
    kvbt_out_if.source               o_text
);
    import kvbt_pkg::*;

    // pending results of the current command: char, '=', newline, end
    logic [3:0]  r_pend, n_pend;
    logic [7:0]  r_char;
    t_end_status r_status;
    logic [3:0]  w_sel;
    logic [3:0]  w_left;
    logic        w_taken;

    // first pending result in emission order
    always_comb begin
        if (r_pend[3]) begin
            w_sel = 4'b1000;
        end else if (r_pend[2]) begin
            w_sel = 4'b0100;
        end else if (r_pend[1]) begin
            w_sel = 4'b0010;
        end else begin
            w_sel = {3'b000, r_pend[0]};
        end
    end

    // drop the sent result, fetch the next command once empty
    assign w_taken = o_text.valid && o_text.ready;
    assign w_left  = w_taken ? (r_pend & ~w_sel) : r_pend;
    assign o_pop   = (w_left == 4'b0000) && i_head_valid;

    always_comb begin
        if (o_pop) begin
            n_pend = {i_head.has_char, i_head.has_eq, i_head.has_nl, i_head.has_end};
        end else begin
            n_pend = w_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 4'b0000;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_char   <= i_head.byte_val;
            r_status <= i_head.status;
        end
    end

    // result fields
    assign o_text.valid = (r_pend != 4'b0000);

    always_comb begin
        o_text.text_char  = 8'd0;
        o_text.char_valid = 1'b0;
        o_text.stream_end = 1'b0;
        o_text.end_status = KVBT_ST_OK;
        case (w_sel)
            4'b1000: begin
                o_text.text_char  = r_char;
                o_text.char_valid = 1'b1;
            end
            4'b0100: begin
                o_text.text_char  = KVBT_CHAR_EQ;
                o_text.char_valid = 1'b1;
            end
            4'b0010: begin
                o_text.text_char  = KVBT_CHAR_NL;
                o_text.char_valid = 1'b1;
            end
            4'b0001: begin
                o_text.stream_end = 1'b1;
                o_text.end_status = r_status;
            end
            default: begin
                o_text.text_char  = 8'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/keyvalue_binary_to_text_decoder.sv =====
// channel   | direction | fields                                          | handshake
// ----------+-----------+-------------------------------------------------+------------
// i_blob    | in        | blob_byte[7:0], blob_last                       | valid/ready
// o_text    | out       | text_char[7:0], char_valid, stream_end,         | valid/ready
//           |           | end_status[1:0]                                 |
//
// A blob byte is taken every cycle while the four-entry queue between the parser
// and the emitter has room; the parser decides a byte in the cycle it arrives.
// The emitter gives one result a cycle while the receiver is ready; a byte causes
// up to four results (character, '=', newline, end); output bandwidth sets rate.
// Reset is synchronous; there is no clearing pass.
// Either side may stall at any time; the queue absorbs up to four requests.
`default_nettype none

module keyvalue_binary_to_text_decoder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kvbt_in_if.sink    i_blob,
    kvbt_out_if.source o_text
);
    import kvbt_pkg::*;

    logic      w_push;
    t_kvbt_cmd w_push_cmd;
    logic      w_q_not_full;
    logic      w_q_valid;
    t_kvbt_cmd w_q_head;
    logic      w_pop;

    // byte parser
    kvbt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_blob    (i_blob),
        .i_q_ready (w_q_not_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    // request queue
    kvbt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_cmd   (w_push_cmd),
        .o_not_full   (w_q_not_full),
        .o_head_valid (w_q_valid),
        .o_head       (w_q_head),
        .i_pop        (w_pop)
    );

    // character emitter
    kvbt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_q_valid),
        .i_head       (w_q_head),
        .o_pop        (w_pop),
        .o_text       (o_text)
    );

    // a last byte always leaves an end request queued or on the output
    a_last_queued : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_blob.valid && i_blob.ready && i_blob.blob_last) |=> (w_q_valid || o_text.valid))
        else $error("end request lost after last byte");

    // nothing pending straight after reset
    a_reset_clear : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_text.valid && !w_q_valid))
        else $error("results pending after reset");

    // character results carry no end marking
    a_char_no_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_text.valid && o_text.char_valid) |->
            (!o_text.stream_end && o_text.end_status == KVBT_ST_OK))
        else $error("character result marked as end");

    // the emitter only fetches when the queue holds a request
    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("fetch from empty queue");

endmodule

`default_nettype wire

// ===== tb/sv/kvbt_tb_pkg.sv =====
package kvbt_tb_pkg;
    import kvbt_pkg::*;

    // where the decoder stands within the current blob
    typedef enum logic [2:0] {
        DEC_HEADER,
        DEC_KEYLEN,
        DEC_VALLEN,
        DEC_KEY,
        DEC_VALUE,
        DEC_DONE,
        DEC_BADSIG
    } t_dec_phase;

    // one text request as it should leave the block
    typedef struct packed {
        logic [7:0]  text_char;
        logic        char_valid;
        logic        stream_end;
        t_end_status end_status;
    } t_text_result;

    class kvbt_text_scoreboard;
        t_dec_phase             phase;
        logic [KVBT_HPOS_W-1:0] hdr_pos;
        logic [7:0]             key_left;
        logic [7:0]             val_left;
        t_text_result           expected_text[$];
        int                     faults;

        function new();
            faults = 0;
            restart();
        endfunction

        // back to the start of a blob
        function void restart();
            phase    = DEC_HEADER;
            hdr_pos  = '0;
            key_left = '0;
            val_left = '0;
        endfunction

        function void push_char(logic [7:0] c);
            t_text_result r;
            r.text_char  = c;
            r.char_valid = 1'b1;
            r.stream_end = 1'b0;
            r.end_status = KVBT_ST_OK;
            expected_text.push_back(r);
        endfunction

        // decode one accepted blob byte into the characters it should produce
        function void take_byte(logic [7:0] b, logic last);
            t_end_status  st;
            t_text_result r;
            st = KVBT_ST_OK;
            case (phase)
                DEC_HEADER: begin
                    if (b != KVBT_SIG[hdr_pos]) begin
                        phase = DEC_BADSIG;
                        st    = KVBT_ST_SIG;
                    end else if (int'(hdr_pos) == KVBT_SIG_LEN - 1) begin
                        hdr_pos = '0;
                        phase   = DEC_KEYLEN;
                    end else begin
                        hdr_pos = hdr_pos + 1'b1;
                        st      = KVBT_ST_SIG;
                    end
                end
                DEC_KEYLEN: begin
                    if (b == 8'h00) begin
                        phase = DEC_DONE;
                    end else begin
                        key_left = b;
                        phase    = DEC_VALLEN;
                        st       = KVBT_ST_TRUNC;
                    end
                end
                DEC_VALLEN: begin
                    val_left = b;
                    phase    = DEC_KEY;
                    st       = KVBT_ST_TRUNC;
                end
                DEC_KEY: begin
                    push_char(b);
                    key_left = key_left - 1'b1;
                    st       = KVBT_ST_TRUNC;
                    if (key_left == 8'h00) begin
                        push_char(KVBT_CHAR_EQ);
                        if (val_left == 8'h00) begin
                            push_char(KVBT_CHAR_NL);
                            phase = DEC_KEYLEN;
                            st    = KVBT_ST_OK;
                        end else begin
                            phase = DEC_VALUE;
                        end
                    end
                end
                DEC_VALUE: begin
                    push_char(b);
                    val_left = val_left - 1'b1;
                    st       = KVBT_ST_TRUNC;
                    if (val_left == 8'h00) begin
                        push_char(KVBT_CHAR_NL);
                        phase = DEC_KEYLEN;
                        st    = KVBT_ST_OK;
                    end
                end
                DEC_BADSIG: st = KVBT_ST_SIG;
                default:    st = KVBT_ST_OK;
            endcase

            // closing request of the blob carries the status
            if (last) begin
                r.text_char  = 8'h00;
                r.char_valid = 1'b0;
                r.stream_end = 1'b1;
                r.end_status = st;
                expected_text.push_back(r);
                restart();
            end
        endfunction

        // compare one accepted text request with the oldest expectation
        function void check_result(logic [7:0] ch, logic cv, logic se, logic [1:0] st);
            t_text_result want;
            if (expected_text.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected text request: char %h valid %b end %b status %0d",
                             ch, cv, se, st);
                return;
            end
            want = expected_text.pop_front();
            if (want.text_char !== ch || want.char_valid !== cv ||
                want.stream_end !== se || want.end_status !== st) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: expected char %h valid %b end %b status %0d, got char %h valid %b end %b status %0d",
                             want.text_char, want.char_valid, want.stream_end,
                             want.end_status, ch, cv, se, st);
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction

        // anything still waiting at the end never arrived
        function void close_out();
            if (expected_text.size() != 0) begin
                faults += expected_text.size();
                $display("%0d expected text requests never arrived", expected_text.size());
                expected_text.delete();
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_keyvalue_binary_to_text_decoder.sv =====
module tb_keyvalue_binary_to_text_decoder;
    import kvbt_pkg::*;
    import kvbt_tb_pkg::*;

    localparam int RANDOM_ITEMS = 430;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 100;

    typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic clk;
    logic rst_n;

    kvbt_in_if  blob_if ();
    kvbt_out_if text_if ();

    keyvalue_binary_to_text_decoder u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_blob  (blob_if),
        .o_text  (text_if)
    );

    kvbt_text_scoreboard sb;

    logic [7:0] blob_q[$];
    int         tail_ignored;
    int         items_sent;
    int         burst_left;
    int         hold_asks;
    int         cycle_count;

    // clock
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // observe both channels at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (blob_if.valid && blob_if.ready)
                sb.take_byte(blob_if.blob_byte, blob_if.blob_last);
            if (text_if.valid && text_if.ready)
                sb.check_result(text_if.text_char, text_if.char_valid,
                                text_if.stream_end, text_if.end_status);
        end
    end

    // receiver: windows of differing stall behaviour, plus long hold-offs on demand
    initial begin
        t_rx_mode rx_mode;
        int       win_left;
        int       hold_left;
        int       hold_seen;
        int       rx_tick;
        rx_mode   = RX_OPEN;
        win_left  = 0;
        hold_left = 0;
        hold_seen = 0;
        rx_tick   = 0;
        text_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            rx_tick++;
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                text_if.ready <= 1'b0;
            end else begin
                if (win_left == 0) begin
                    rx_mode  = t_rx_mode'($urandom_range(0, 3));
                    win_left = $urandom_range(16, 80);
                end
                win_left--;
                case (rx_mode)
                    RX_OPEN:   text_if.ready <= 1'b1;
                    RX_HALF:   text_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: text_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   text_if.ready <= (rx_tick % 3 != 0);
                endcase
            end
        end
    end

    // offer one byte, in bursts separated by random gaps
    task automatic put_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0) begin
            blob_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        blob_if.valid     <= 1'b1;
        blob_if.blob_byte <= b;
        blob_if.blob_last <= last;
        do @(posedge clk); while (!blob_if.ready);
    endtask

    task automatic send_blob();
        foreach (blob_q[i])
            put_byte(blob_q[i], i == blob_q.size() - 1);
        items_sent += blob_q.size() - tail_ignored;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic void add_sig(int n);
        for (int i = 0; i < n; i++)
            blob_q.push_back(KVBT_SIG[i]);
    endfunction

    // one random blob, mostly well formed with random records
    task automatic build_random_blob();
        int         kind;
        int         nrec;
        int         klen;
        int         vlen;
        int         cut;
        int         rec_start;
        int         pos;
        logic [7:0] bad;
        blob_q.delete();
        tail_ignored = 0;
        klen         = 1;
        vlen         = 0;
        rec_start    = 0;
        kind         = $urandom_range(0, 99);
        if (kind < 6) begin
            // header cut short
            add_sig($urandom_range(1, KVBT_SIG_LEN - 1));
        end else if (kind < 14) begin
            // wrong signature byte, then bytes that are ignored
            pos = $urandom_range(0, KVBT_SIG_LEN - 1);
            add_sig(pos);
            do bad = 8'($urandom_range(0, 255)); while (bad == KVBT_SIG[pos]);
            blob_q.push_back(bad);
            tail_ignored = $urandom_range(0, 4);
            repeat (tail_ignored) blob_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_sig(KVBT_SIG_LEN);
            nrec = $urandom_range(0, 4);
            if (kind < 26 && nrec == 0)
                nrec = 1;
            for (int k = 0; k < nrec; k++) begin
                rec_start = blob_q.size();
                klen = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(1, 8);
                if ($urandom_range(0, 39) == 0)
                    vlen = 255;
                else
                    vlen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
                blob_q.push_back(8'(klen));
                blob_q.push_back(8'(vlen));
                repeat (klen + vlen) blob_q.push_back(8'($urandom_range(0, 255)));
            end
            if (kind < 26) begin
                // stop part way through the last record
                cut = $urandom_range(1, 1 + klen + vlen);
                while (blob_q.size() > rec_start + cut)
                    void'(blob_q.pop_back());
            end else if ($urandom_range(0, 2) != 0) begin
                // end marker, possibly with trailing bytes
                blob_q.push_back(8'h00);
                tail_ignored = $urandom_range(0, 3);
                repeat (tail_ignored) blob_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // stimulus
    initial begin
        bit hold_asked;
        bit drain_done;
        int random_base;
        sb                = new();
        rst_n             = 1'b0;
        blob_if.valid     = 1'b0;
        blob_if.blob_byte = 8'h00;
        blob_if.blob_last = 1'b0;
        items_sent        = 0;
        burst_left        = 0;
        hold_asks         = 0;
        cycle_count       = 0;
        hold_asked        = 0;
        drain_done        = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // signature alone
        blob_q.delete(); tail_ignored = 0;
        add_sig(KVBT_SIG_LEN);
        send_blob();

        // header cut short
        blob_q.delete(); tail_ignored = 0;
        add_sig(2);
        send_blob();

        // wrong first byte, flagged last
        blob_q.delete(); tail_ignored = 0;
        blob_q.push_back(8'h7E);
        send_blob();

        // wrong second byte, then an ignored byte
        blob_q.delete(); tail_ignored = 1;
        add_sig(1);
        blob_q.push_back(8'h46);
        blob_q.push_back(8'h00);
        send_blob();

        // key only with empty value, end marker, trailing byte
        blob_q.delete(); tail_ignored = 1;
        add_sig(KVBT_SIG_LEN);
        blob_q.push_back(8'h01);
        blob_q.push_back(8'h00);
        blob_q.push_back(8'hFF);
        blob_q.push_back(8'h00);
        blob_q.push_back(8'h55);
        send_blob();

        // record ending inside its value
        blob_q.delete(); tail_ignored = 0;
        add_sig(KVBT_SIG_LEN);
        blob_q.push_back(8'h01);
        blob_q.push_back(8'h02);
        blob_q.push_back(8'h00);
        blob_q.push_back(8'h80);
        send_blob();

        // sender pauses until all text has come out
        @(negedge clk);
        blob_if.valid <= 1'b0;
        wait_drained();

        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            build_random_blob();
            send_blob();
            // receiver holds off while the sender keeps offering
            if (!hold_asked && items_sent - random_base >= 150) begin
                hold_asks++;
                hold_asked = 1;
            end
            if (!drain_done && items_sent - random_base >= 300) begin
                @(negedge clk);
                blob_if.valid <= 1'b0;
                wait_drained();
                drain_done = 1;
            end
        end

        @(negedge clk);
        blob_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();
        if (sb.faults == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
